/* src/cpr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants of the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int PAGE_W      = 6;
  localparam int FRAME_W     = 6;
  localparam int SLOT_W      = 6;
  localparam int NUM_PAGES   = 64;
  localparam int NUM_FRAMES  = 64;
  localparam int SLOT_LIMIT  = 64;
  localparam int NEXT_SLOT_W = 7;
  localparam int ALLOC_W     = 7;
  localparam int LIMIT_W     = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

  localparam logic POLICY_CLOCK  = 1'b0;
  localparam logic POLICY_CLOCKM = 1'b1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [PAGE_W-1:0] page;
    logic [FRAME_W-1:0] frame;
  } cpr_in_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] assigned_frame;
    logic               swap_out;
    logic [PAGE_W-1:0]  victim_page;
    logic [SLOT_W-1:0]  swap_out_slot;
    logic               swap_in;
    logic [SLOT_W-1:0]  swap_in_slot;
    logic               no_free_frame;
  } cpr_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACCESS,
    S_LOAD_READ,
    S_LOAD_CHECK,
    S_SWEEP,
    S_VICTIM,
    S_VICTIM_SLOT,
    S_FILL_READ,
    S_FILL,
    S_RESULT
  } cpr_state_t;

  typedef struct packed {
    logic start;
    logic access_step;
    logic load_check;
    logic sweep_step;
    logic victim;
    logic victim_slot;
    logic fill_read;
    logic fill;
    logic result_load;
  } cpr_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       access_done;
    logic       present;
    logic       below_limit;
    logic       place_ok;
    logic       sweep_found;
  } cpr_status_t;

endpackage
`default_nettype wire

/* src/cpr_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/cpr_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer: steps one transaction through lookup, sweep, eviction and fill.
// ----------------------------------------------------------------------------
module cpr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire cpr_pkg::cpr_status_t status,
  output cpr_pkg::cpr_cmd_t        cmd
);
  import cpr_pkg::*;

  cpr_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (status.op == OP_READ || status.op == OP_WRITE) begin
            state_next = S_ACCESS;
          end else if (status.op == OP_LOAD) begin
            state_next = S_LOAD_READ;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_ACCESS: begin
        cmd.access_step = 1'b1;
        if (status.access_done) begin
          state_next = S_RESULT;
        end
      end
      S_LOAD_READ: begin
        state_next = S_LOAD_CHECK;
      end
      S_LOAD_CHECK: begin
        cmd.load_check = 1'b1;
        if (status.present) begin
          state_next = S_RESULT;
        end else if (status.below_limit) begin
          state_next = status.place_ok ? S_FILL_READ : S_RESULT;
        end else begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_found) begin
          state_next = S_VICTIM;
        end
      end
      S_VICTIM: begin
        cmd.victim = 1'b1;
        state_next = S_VICTIM_SLOT;
      end
      S_VICTIM_SLOT: begin
        cmd.victim_slot = 1'b1;
        state_next = S_FILL_READ;
      end
      S_FILL_READ: begin
        cmd.fill_read = 1'b1;
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.result_load = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/cpr_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_dpath
// Page tables, resident ring, clock hand, swap slot allocation and results.
// ----------------------------------------------------------------------------
module cpr_dpath #(
  parameter int MAX_RESIDENT = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cpr_pkg::cpr_in_t               in_item,
  input  wire logic                           cfg_we,
  input  wire logic [cpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cpr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire cpr_pkg::cpr_cmd_t              cmd,
  output cpr_pkg::cpr_status_t                status,
  output cpr_pkg::cpr_out_t                   out_item
);
  import cpr_pkg::*;

  localparam int CW = $clog2(MAX_RESIDENT + 1);
  localparam int HW = (MAX_RESIDENT > 1) ? $clog2(MAX_RESIDENT) : 1;
  localparam int AW = CW + 1;
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int SW = CW + 2;

  logic                 policy;
  logic [LIMIT_W-1:0]   resident_limit;

  logic [1:0]           op_q;
  logic [PAGE_W-1:0]    page_q;
  logic [FRAME_W-1:0]   frame_q;

  logic [NUM_PAGES-1:0] present, use_bit, dirty, has_slot;
  logic [PAGE_W-1:0]    ring_page  [MAX_RESIDENT];
  logic [FRAME_W-1:0]   ring_frame [MAX_RESIDENT];
  logic [CW-1:0]        ring_count;
  logic [HW-1:0]        hand;
  logic [ALLOC_W-1:0]   alloc_count;
  logic [NEXT_SLOT_W-1:0] next_slot;

  logic [CW-1:0]        idx;
  logic [SW-1:0]        steps;
  logic [1:0]           round;
  logic                 phase;
  logic                 vic_read;

  cpr_out_t             res;

  logic [HW-1:0]        rd_idx;
  logic [PAGE_W-1:0]    rd_page;
  logic [FRAME_W-1:0]   rd_frame;
  logic                 rd_use, rd_dirty;
  logic [HW-1:0]        hand_adv;
  logic [AW-1:0]        hand_inc;
  logic [LW-1:0]        limit_eff;
  logic [SW-1:0]        plain_max;
  logic                 steps_end;
  logic                 acc_match;
  logic [SLOT_W-1:0]    new_slot;

  logic                 frame_we;
  logic [FRAME_W-1:0]   frame_wdata;
  logic [FRAME_W-1:0]   frame_rdata;
  logic                 slot_we;
  logic [PAGE_W-1:0]    slot_raddr;
  logic [SLOT_W-1:0]    slot_rdata;
  logic                 place;

  cpr_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_PAGES)) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (page_q),
    .wdata (frame_wdata),
    .raddr (page_q),
    .rdata (frame_rdata)
  );

  cpr_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_PAGES)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (rd_page),
    .wdata (new_slot),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  always_comb begin
    rd_idx    = cmd.access_step ? idx[HW-1:0] : hand;
    rd_page   = ring_page[rd_idx];
    rd_frame  = ring_frame[rd_idx];
    rd_use    = use_bit[rd_page];
    rd_dirty  = dirty[rd_page];
    hand_inc  = AW'(hand) + AW'(1);
    hand_adv  = (hand_inc >= AW'(ring_count)) ? '0 : hand_inc[HW-1:0];
    if (resident_limit == '0) begin
      limit_eff = LW'(1);
    end else if (LW'(resident_limit) > LW'(MAX_RESIDENT)) begin
      limit_eff = LW'(MAX_RESIDENT);
    end else begin
      limit_eff = LW'(resident_limit);
    end
    plain_max = SW'({ring_count, 1'b0}) + SW'(1);
    steps_end = (steps == SW'(ring_count));
    acc_match = (idx < ring_count) && (rd_frame == frame_q);
    new_slot  = (next_slot < NEXT_SLOT_W'(SLOT_LIMIT)) ? next_slot[SLOT_W-1:0]
                                                      : SLOT_W'(SLOT_LIMIT - 1);

    status.op          = in_item.operation;
    status.access_done = acc_match || (idx >= ring_count);
    status.present     = present[page_q];
    status.below_limit = LW'(ring_count) < limit_eff;
    status.place_ok    = alloc_count < ALLOC_W'(NUM_FRAMES);
    if (policy == POLICY_CLOCK) begin
      status.sweep_found = (steps == plain_max) || !rd_use;
    end else begin
      status.sweep_found = (round == 2'd3) ||
                           (!steps_end && !rd_use && (rd_dirty == phase));
    end

    place = cmd.load_check && !present[page_q] && status.below_limit &&
            status.place_ok;
    frame_we    = place || cmd.victim;
    frame_wdata = cmd.victim ? rd_frame : alloc_count[FRAME_W-1:0];
    slot_we     = cmd.victim && rd_dirty && !has_slot[rd_page];
    slot_raddr  = cmd.victim ? rd_page : page_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy         <= POLICY_CLOCK;
      resident_limit <= LIMIT_W'(4);
      present        <= '0;
      use_bit        <= '0;
      dirty          <= '0;
      has_slot       <= '0;
      ring_count     <= '0;
      hand           <= '0;
      alloc_count    <= '0;
      next_slot      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY: policy <= cfg_data[0];
          CFG_LIMIT:  resident_limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (cmd.access_step && acc_match) begin
        use_bit[rd_page] <= 1'b1;
        if (op_q == OP_WRITE) begin
          dirty[rd_page] <= 1'b1;
        end
      end

      if (place) begin
        ring_count  <= ring_count + CW'(1);
        alloc_count <= alloc_count + ALLOC_W'(1);
      end

      if (cmd.load_check && !present[page_q] && !status.below_limit) begin
        if (AW'(hand) >= AW'(ring_count)) begin
          hand <= '0;
        end
      end

      if (cmd.sweep_step && !status.sweep_found) begin
        if (policy == POLICY_CLOCK) begin
          use_bit[rd_page] <= 1'b0;
          hand <= hand_adv;
        end else if (!steps_end) begin
          if (phase) begin
            use_bit[rd_page] <= 1'b0;
          end
          hand <= hand_adv;
        end
      end

      if (cmd.victim) begin
        if (slot_we) begin
          has_slot[rd_page] <= 1'b1;
          if (next_slot < NEXT_SLOT_W'(SLOT_LIMIT)) begin
            next_slot <= next_slot + NEXT_SLOT_W'(1);
          end
        end
        present[rd_page] <= 1'b0;
        use_bit[rd_page] <= 1'b0;
        hand <= hand_adv;
      end

      if (cmd.fill_read) begin
        present[page_q] <= 1'b1;
        use_bit[page_q] <= 1'b1;
      end

      if (cmd.fill && dirty[page_q]) begin
        dirty[page_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q    <= in_item.operation;
      page_q  <= in_item.page;
      frame_q <= in_item.frame;
      res     <= '0;
      idx     <= '0;
    end

    if (cmd.access_step && !status.access_done) begin
      idx <= idx + CW'(1);
    end
    if (cmd.access_step && acc_match) begin
      res.hit <= 1'b1;
    end

    if (cmd.load_check) begin
      steps <= '0;
      round <= '0;
      phase <= 1'b0;
      if (present[page_q]) begin
        res.hit            <= 1'b1;
        res.assigned_frame <= frame_rdata;
      end else if (status.below_limit) begin
        if (status.place_ok) begin
          ring_page[ring_count[HW-1:0]]  <= page_q;
          ring_frame[ring_count[HW-1:0]] <= alloc_count[FRAME_W-1:0];
          res.assigned_frame             <= alloc_count[FRAME_W-1:0];
        end else begin
          res.no_free_frame <= 1'b1;
        end
      end
    end

    if (cmd.sweep_step && !status.sweep_found) begin
      if (policy == POLICY_CLOCK || !steps_end) begin
        steps <= steps + SW'(1);
      end else begin
        steps <= '0;
        phase <= !phase;
        if (phase) begin
          round <= round + 2'd1;
        end
      end
    end

    if (cmd.victim) begin
      res.victim_page    <= rd_page;
      res.assigned_frame <= rd_frame;
      ring_page[hand]    <= page_q;
      ring_frame[hand]   <= rd_frame;
      vic_read           <= rd_dirty && has_slot[rd_page];
      if (rd_dirty) begin
        res.swap_out      <= 1'b1;
        res.swap_out_slot <= new_slot;
      end
    end

    if (cmd.victim_slot && vic_read) begin
      res.swap_out_slot <= slot_rdata;
    end

    if (cmd.fill && dirty[page_q]) begin
      res.swap_in      <= 1'b1;
      res.swap_in_slot <= slot_rdata;
    end

    if (cmd.result_load) begin
      out_item <= res;
    end
  end

endmodule
`default_nettype wire

/* src/clock_page_replacement.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clock_page_replacement
// Resident-set manager with clock and enhanced clock page replacement.
// ----------------------------------------------------------------------------
// One transaction is in work at a time; the next is taken while a result
// waits in the output register. The ring is examined one entry per cycle.
// A read or write access walks the ring until an entry's frame matches or
// the ring ends. A load of a present page, or one that finds no free frame,
// goes from the check to the result; a placement below the limit writes the
// frame table and fills a new ring entry. A replacement sweeps the hand under
// plain or enhanced clock, evicts the victim, reads its swap slot and fills.
// ----------------------------------------------------------------------------
module clock_page_replacement #(
  parameter int MAX_RESIDENT = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire cpr_pkg::cpr_in_t               in_item,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output cpr_pkg::cpr_out_t                   out_item,
  input  wire logic                           cfg_we,
  input  wire logic [cpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cpr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cpr_pkg::*;

  cpr_cmd_t    cmd;
  cpr_status_t status;

  cpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cpr_dpath #(.MAX_RESIDENT(MAX_RESIDENT)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

/* src/cpr_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_checker
// Port-level checks of the clock page replacement block.
// ----------------------------------------------------------------------------
module cpr_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire cpr_pkg::cpr_out_t              out_item
);
  import cpr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped or changed while stalled");

  a_hit_no_swap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.hit |-> !out_item.swap_out && !out_item.swap_in)
    else $error("hit reported together with swap traffic");

  a_no_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.no_free_frame |->
      out_item.assigned_frame == '0 && !out_item.hit && !out_item.swap_in)
    else $error("frame reported on a failed allocation");

  a_swap_slots: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.swap_in || out_item.swap_in_slot == '0) &&
                  (out_item.swap_out || out_item.swap_out_slot == '0))
    else $error("swap slot reported without swap");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (.*);
`default_nettype wire

/* verif/tb_clock_page_replacement.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_clock_page_replacement
// Self-checking testbench for the clock page replacement block. A queue of
// access and load transactions feeds a valid/ready driver; a scoreboard model
// of the resident set predicts each result and the monitor compares it field
// by field. Phases switch policy and resident limit while the block is idle.
// ----------------------------------------------------------------------------
module tb_clock_page_replacement;
  import cpr_pkg::*;

  localparam int MAX_RES = 16;
  localparam int WATCHDOG = 20000;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  cpr_in_t in_item;
  logic out_valid;
  logic out_ready;
  cpr_out_t out_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  clock_page_replacement #(.MAX_RESIDENT(MAX_RES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // resident-set shadow
  logic       rs_policy;
  logic [4:0] rs_limit;
  logic       pg_present [NUM_PAGES];
  logic       pg_use [NUM_PAGES];
  logic       pg_dirty [NUM_PAGES];
  logic [5:0] pg_frame [NUM_PAGES];
  logic       pg_has_slot [NUM_PAGES];
  logic [5:0] pg_slot [NUM_PAGES];
  logic [5:0] ring [MAX_RES];
  int         ring_n;
  int         hand_pos;
  logic       frm_busy [NUM_FRAMES];
  int         slot_next;

  cpr_in_t  pending_items[$];
  cpr_out_t expected_results[$];
  int       errors = 0;
  int       idle_cycles;
  bit       in_taken;
  bit       hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void shadow_reset();
    for (int i = 0; i < NUM_PAGES; i++) begin
      pg_present[i] = 1'b0; pg_use[i] = 1'b0; pg_dirty[i] = 1'b0;
      pg_frame[i] = '0; pg_has_slot[i] = 1'b0; pg_slot[i] = '0;
    end
    for (int i = 0; i < NUM_FRAMES; i++) frm_busy[i] = 1'b0;
    for (int i = 0; i < MAX_RES; i++) ring[i] = '0;
    ring_n = 0;
    hand_pos = 0;
    slot_next = 0;
  endfunction

  function automatic void step_hand();
    hand_pos++;
    if (hand_pos >= ring_n) hand_pos = 0;
  endfunction

  function automatic void find_victim();
    logic [5:0] p;
    if (hand_pos >= ring_n) hand_pos = 0;
    if (rs_policy == POLICY_CLOCK) begin
      for (int s = 0; s < 2 * ring_n + 1; s++) begin
        p = ring[hand_pos];
        if (!pg_use[p]) return;
        pg_use[p] = 1'b0;
        step_hand();
      end
      return;
    end
    for (int r = 0; r < 3; r++) begin
      for (int s = 0; s < ring_n; s++) begin
        p = ring[hand_pos];
        if (!pg_use[p] && !pg_dirty[p]) return;
        step_hand();
      end
      for (int s = 0; s < ring_n; s++) begin
        p = ring[hand_pos];
        if (!pg_use[p] && pg_dirty[p]) return;
        pg_use[p] = 1'b0;
        step_hand();
      end
    end
  endfunction

  function automatic cpr_out_t resident_set_step(cpr_in_t t);
    cpr_out_t r;
    int lim;
    int f;
    bit placed;
    logic [5:0] v;
    logic [5:0] p;
    r = '0;
    if (t.operation == OP_READ || t.operation == OP_WRITE) begin
      for (int i = 0; i < ring_n; i++) begin
        p = ring[i];
        if (pg_frame[p] == t.frame) begin
          r.hit = 1'b1;
          pg_use[p] = 1'b1;
          if (t.operation == OP_WRITE) pg_dirty[p] = 1'b1;
          break;
        end
      end
    end else if (t.operation == OP_LOAD) begin
      lim = int'(rs_limit);
      if (lim == 0) lim = 1;
      if (lim > MAX_RES) lim = MAX_RES;
      if (pg_present[t.page]) begin
        r.hit = 1'b1;
        r.assigned_frame = pg_frame[t.page];
      end else begin
        placed = 1'b0;
        if (ring_n < lim) begin
          f = 0;
          while (f < NUM_FRAMES && frm_busy[f]) f++;
          if (f < NUM_FRAMES) begin
            frm_busy[f] = 1'b1;
            pg_frame[t.page] = f[5:0];
            ring[ring_n] = t.page;
            ring_n++;
            placed = 1'b1;
          end else begin
            r.no_free_frame = 1'b1;
          end
        end else begin
          find_victim();
          v = ring[hand_pos];
          r.victim_page = v;
          if (pg_dirty[v]) begin
            if (!pg_has_slot[v]) begin
              pg_slot[v] = slot_next < SLOT_LIMIT ? slot_next[5:0] : 6'd63;
              pg_has_slot[v] = 1'b1;
              if (slot_next < SLOT_LIMIT) slot_next++;
            end
            r.swap_out = 1'b1;
            r.swap_out_slot = pg_slot[v];
          end
          pg_present[v] = 1'b0;
          pg_use[v] = 1'b0;
          pg_frame[t.page] = pg_frame[v];
          ring[hand_pos] = t.page;
          step_hand();
          placed = 1'b1;
        end
        if (placed) begin
          pg_present[t.page] = 1'b1;
          pg_use[t.page] = 1'b1;
          r.assigned_frame = pg_frame[t.page];
          if (pg_dirty[t.page]) begin
            r.swap_in = 1'b1;
            r.swap_in_slot = pg_slot[t.page];
            pg_dirty[t.page] = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  // driver
  int gap;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item <= '0;
      gap <= 0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (gap > 0) begin
      in_valid <= 1'b0;
      gap <= gap - 1;
    end else if (pending_items.size() > 0) begin
      in_item <= pending_items.pop_front();
      in_valid <= 1'b1;
      gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
           : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  int stall;
  int hold_off;
  bit hold_done;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall <= 0;
      hold_off <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_off <= 300;
      hold_done <= 1'b1;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (stall > 0) begin
      out_ready <= 1'b0;
      stall <= stall - 1;
    end else begin
      out_ready <= 1'b1;
      stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
             : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      shadow_reset();
      in_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        expected_results.push_back(resident_set_step(in_item));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          errors++;
        end else begin
          cpr_out_t e;
          e = expected_results.pop_front();
          if (e.hit != out_item.hit)
            $display("%0t: hit exp %0d got %0d", $time, e.hit, out_item.hit);
          if (e.assigned_frame != out_item.assigned_frame)
            $display("%0t: assigned_frame exp %0d got %0d", $time,
                     e.assigned_frame, out_item.assigned_frame);
          if (e.swap_out != out_item.swap_out)
            $display("%0t: swap_out exp %0d got %0d", $time, e.swap_out,
                     out_item.swap_out);
          if (e.victim_page != out_item.victim_page)
            $display("%0t: victim_page exp %0d got %0d", $time, e.victim_page,
                     out_item.victim_page);
          if (e.swap_out_slot != out_item.swap_out_slot)
            $display("%0t: swap_out_slot exp %0d got %0d", $time,
                     e.swap_out_slot, out_item.swap_out_slot);
          if (e.swap_in != out_item.swap_in)
            $display("%0t: swap_in exp %0d got %0d", $time, e.swap_in,
                     out_item.swap_in);
          if (e.swap_in_slot != out_item.swap_in_slot)
            $display("%0t: swap_in_slot exp %0d got %0d", $time,
                     e.swap_in_slot, out_item.swap_in_slot);
          if (e.no_free_frame != out_item.no_free_frame)
            $display("%0t: no_free_frame exp %0d got %0d", $time,
                     e.no_free_frame, out_item.no_free_frame);
          if (e != out_item) errors++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic cpr_in_t make_item(logic [1:0] op, logic [5:0] pg,
                                        logic [5:0] fr);
    cpr_in_t t;
    t.operation = op;
    t.page = pg;
    t.frame = fr;
    return t;
  endfunction

  // mostly loads from a working set of span pages and accesses to frames 0 to 17, plus some ignored and random items
  function automatic cpr_in_t random_item(int span);
    int k;
    k = $urandom_range(0, 99);
    if (k < 3) return make_item(OP_IGNORED, 6'($urandom), 6'($urandom));
    if (k < 45)
      return make_item(OP_LOAD, 6'($urandom_range(0, span - 1)), 6'($urandom));
    if (k < 90)
      return make_item(($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE,
                       6'($urandom), 6'($urandom_range(0, 17)));
    return make_item(2'($urandom_range(0, 2)), 6'($urandom), 6'($urandom));
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) rs_policy = val[0];
    else rs_limit = val;
  endtask

  initial begin
    logic [4:0] limits [6];
    clk = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rs_policy = POLICY_CLOCK;
    rs_limit = 5'd4;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: default setting, plain clock, limit 4
    pending_items.push_back(make_item(OP_READ, 0, 0));
    pending_items.push_back(make_item(OP_LOAD, 63, 0));
    pending_items.push_back(make_item(OP_LOAD, 0, 63));
    pending_items.push_back(make_item(OP_LOAD, 63, 5));
    pending_items.push_back(make_item(OP_WRITE, 0, 1));
    pending_items.push_back(make_item(OP_READ, 63, 63));
    pending_items.push_back(make_item(OP_IGNORED, 63, 63));
    pending_items.push_back(make_item(OP_LOAD, 21, 42));
    pending_items.push_back(make_item(OP_LOAD, 42, 21));
    pending_items.push_back(make_item(OP_WRITE, 0, 2));
    pending_items.push_back(make_item(OP_LOAD, 7, 0));
    pending_items.push_back(make_item(OP_LOAD, 8, 0));
    pending_items.push_back(make_item(OP_LOAD, 21, 0));
    pending_items.push_back(make_item(OP_LOAD, 1, 0));
    wait_drained();

    write_reg(CFG_POLICY, 5'(POLICY_CLOCKM));
    write_reg(CFG_LIMIT, 5'd0);
    pending_items.push_back(make_item(OP_LOAD, 5, 0));
    pending_items.push_back(make_item(OP_WRITE, 0, 0));
    pending_items.push_back(make_item(OP_LOAD, 6, 0));
    pending_items.push_back(make_item(OP_LOAD, 5, 0));
    pending_items.push_back(make_item(OP_READ, 0, 0));
    pending_items.push_back(make_item(OP_LOAD, 9, 0));
    wait_drained();

    limits = '{5'd16, 5'd31, 5'd2, 5'd1, 5'd8, 5'd12};
    for (int ph = 0; ph < 12; ph++) begin
      int span;
      write_reg(CFG_POLICY, 5'(ph[0]));
      write_reg(CFG_LIMIT, limits[ph % 6]);
      span = (ph % 3 == 0) ? 64 : int'($urandom_range(int'(limits[ph % 6]) + 2, 24));
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < 130; n++) pending_items.push_back(random_item(span));
      wait_drained();
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
